[src/dts_pkg.sv]
// shared types and constants for the dds tuning word serializer
package dts_pkg;

  localparam int FREQ_W      = 26;
  localparam int FTW_W       = 32;
  localparam int CTRL_W      = 8;
  localparam int TOTAL_BITS  = FTW_W + CTRL_W;
  localparam int BIT_CNT_W   = $clog2(TOTAL_BITS);
  localparam int REM_W       = 20;
  localparam int QUEUE_DEPTH = 2;

  // tuning word = (f * recip) >> RECIP_SHIFT, recip split at RECIP_SPLIT bits
  localparam int RECIP_W     = 25;
  localparam int RECIP_SPLIT = 26;
  localparam int RECIP_SHIFT = 45;
  localparam int PROD_W      = FREQ_W + RECIP_W;

  localparam logic [FREQ_W-1:0]  FREQ_MAX_HZ = 26'd62500000;
  localparam logic [FREQ_W-1:0]  FTW_PER_MHZ = 26'd34359738;
  localparam logic [REM_W-1:0]   HZ_PER_MHZ  = 20'd1000000;
  localparam logic [FTW_W-1:0]   FTW_MAX     = 32'd2147483625;
  localparam logic [RECIP_W-1:0] RECIP_HI    = 25'd18014398;
  localparam logic [RECIP_W-1:0] RECIP_LO    = 25'd21242909;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_MUL,
    FE_ADD,
    FE_DONE
  } front_state_t;

  // one tuning word moving between front, queue and back
  typedef struct packed {
    logic             valid;
    logic [FTW_W-1:0] word;
  } ftw_xfer_t;

endpackage

[src/dts_channel_if.sv]
// channel interfaces for frequency requests and serial bits
interface dts_in_if;
  import dts_pkg::*;

  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] freq_hz;

  modport source (output valid, output freq_hz, input ready);
  modport sink (input valid, input freq_hz, output ready);
endinterface

interface dts_out_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic last_bit;

  modport source (output valid, output data_bit, output last_bit, input ready);
  modport sink (input valid, input data_bit, input last_bit, output ready);
endinterface

[src/dts_front.sv]
// front end: accepts a frequency, saturates it and computes the tuning word
module dts_front (
  input  logic                clk,
  input  logic                rst_n,
  dts_in_if.sink              in_ch,
  output dts_pkg::ftw_xfer_t  ftw_o,
  input  logic                ftw_ready
);
  import dts_pkg::*;

  front_state_t          state_r, state_nxt;
  logic [FREQ_W-1:0]     freq_r, freq_nxt;
  logic [PROD_W-1:0]     lo_r, lo_nxt;
  logic [PROD_W-1:0]     hi_r, hi_nxt;
  logic [FTW_W-1:0]      quot_r, quot_nxt;
  logic [PROD_W-1:0]     acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    freq_r <= freq_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    quot_r <= quot_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    freq_nxt  = freq_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    quot_nxt  = quot_r;
    // floor(f * recip * 2^-26) rebuilt from the two partial products
    acc       = hi_r + PROD_W'(lo_r[PROD_W-1:RECIP_SPLIT]);
    case (state_r)
      FE_IDLE: begin
        if (in_ch.valid) begin
          freq_nxt  = (in_ch.freq_hz > FREQ_MAX_HZ) ? FREQ_MAX_HZ : in_ch.freq_hz;
          state_nxt = FE_MUL;
        end
      end
      FE_MUL: begin
        lo_nxt    = PROD_W'(freq_r) * PROD_W'(RECIP_LO);
        hi_nxt    = PROD_W'(freq_r) * PROD_W'(RECIP_HI);
        state_nxt = FE_ADD;
      end
      FE_ADD: begin
        quot_nxt  = acc[RECIP_SHIFT-RECIP_SPLIT +: FTW_W];
        state_nxt = FE_DONE;
      end
      FE_DONE: begin
        if (ftw_ready) begin
          state_nxt = FE_IDLE;
        end
      end
      default: begin
        state_nxt = FE_IDLE;
      end
    endcase
  end

  assign in_ch.ready = (state_r == FE_IDLE);
  assign ftw_o.valid = (state_r == FE_DONE);
  assign ftw_o.word  = quot_r;

endmodule

[src/dts_queue.sv]
// short tuning word queue between front and back
module dts_queue #(
  parameter int DEPTH = dts_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dts_pkg::ftw_xfer_t push_i,
  output logic               push_ready,
  output dts_pkg::ftw_xfer_t pop_o,
  input  logic               pop_ready
);
  import dts_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [FTW_W-1:0] mem [DEPTH];
  logic [IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready  = (cnt_r != CNT_W'(DEPTH));
  assign pop_o.valid = (cnt_r != '0);
  assign pop_o.word  = mem[rd_ptr_r];
  assign do_push     = push_i.valid && push_ready;
  assign do_pop      = pop_o.valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_i.word;
    end
  end

endmodule

[src/dts_back.sv]
// back end: shifts tuning word then control byte out lsb first
module dts_back (
  input  logic                clk,
  input  logic                rst_n,
  input  dts_pkg::ftw_xfer_t  word_i,
  output logic                word_ready,
  input  logic                cfg_we,
  input  logic [dts_pkg::CTRL_W-1:0] cfg_data,
  dts_out_if.source           out_ch
);
  import dts_pkg::*;

  logic [CTRL_W-1:0]     ctrl_r, ctrl_nxt;
  logic [TOTAL_BITS-1:0] shift_r, shift_nxt;
  logic [BIT_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  active_r, active_nxt;
  logic                  ov_r, ov_nxt;
  logic                  data_r, data_nxt;
  logic                  last_r, last_nxt;
  logic                  can_emit;
  logic                  last_cnt;

  assign can_emit   = !ov_r || out_ch.ready;
  assign last_cnt   = (cnt_r == BIT_CNT_W'(TOTAL_BITS - 1));
  // next word loads in the same cycle the last bit goes out
  assign word_ready = !active_r || (can_emit && last_cnt);

  always_comb begin
    ctrl_nxt   = cfg_we ? cfg_data : ctrl_r;
    shift_nxt  = shift_r;
    cnt_nxt    = cnt_r;
    active_nxt = active_r;
    ov_nxt     = ov_r;
    data_nxt   = data_r;
    last_nxt   = last_r;
    if (active_r && can_emit) begin
      ov_nxt    = 1'b1;
      data_nxt  = shift_r[0];
      last_nxt  = last_cnt;
      shift_nxt = shift_r >> 1;
      cnt_nxt   = cnt_r + 1'b1;
      if (last_cnt) begin
        active_nxt = 1'b0;
      end
    end else if (can_emit) begin
      ov_nxt = 1'b0;
    end
    if (word_i.valid && word_ready) begin
      shift_nxt  = {ctrl_r, word_i.word};
      cnt_nxt    = '0;
      active_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r   <= '0;
      cnt_r    <= '0;
      active_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      ctrl_r   <= ctrl_nxt;
      cnt_r    <= cnt_nxt;
      active_r <= active_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    data_r  <= data_nxt;
    last_r  <= last_nxt;
  end

  assign out_ch.valid    = ov_r;
  assign out_ch.data_bit = data_r;
  assign out_ch.last_bit = last_r;

endmodule

[src/dds_tuning_word_serializer.sv]
// an accepted request passes the multiply and shift-add states, the queue and the shift register before its first bit
// the tuning word takes a state of two split multiplies followed by a shift-add state
// the serializer sends 40 bits at one per cycle while the receiver is ready
// a queue between multiplier and serializer lets the next word be computed meanwhile
// synchronous active-low reset clears control state and the control byte to zero
module dds_tuning_word_serializer #(
  parameter int QUEUE_DEPTH = dts_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  dts_in_if.sink                     in_ch,
  dts_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [dts_pkg::CTRL_W-1:0] cfg_data
);
  import dts_pkg::*;

  ftw_xfer_t front_xfer;
  ftw_xfer_t back_xfer;
  logic      front_ready;
  logic      back_ready;

  dts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .ftw_o     (front_xfer),
    .ftw_ready (front_ready)
  );

  dts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (front_xfer),
    .push_ready (front_ready),
    .pop_o      (back_xfer),
    .pop_ready  (back_ready)
  );

  dts_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .word_i     (back_xfer),
    .word_ready (back_ready),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .out_ch     (out_ch)
  );

  // saturated frequency can never give a word above the nyquist tuning word
  a_ftw_range: assert property (@(posedge clk) disable iff (!rst_n)
    front_xfer.valid |-> (front_xfer.word <= FTW_MAX))
    else $error("tuning word out of range");

  // front takes one request at a time
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("front accepted while busy");

  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    front_xfer.valid |-> !in_ch.ready)
    else $error("front ready with a word pending");

  a_word_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (front_xfer.valid && !front_ready) |=> (front_xfer.valid && $stable(front_xfer.word)))
    else $error("pending tuning word changed");

endmodule

[dv/testbench.sv]
// self-checking testbench for the dds tuning word serializer
`timescale 1ns / 1ps

module testbench;
  import dts_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PCT    = 23;

  typedef struct packed {
    logic data_bit;
    logic last_bit;
  } serial_bit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              drv_valid = 1'b0;
  logic [FREQ_W-1:0] drv_freq = '0;
  logic              sink_ready = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CTRL_W-1:0] cfg_data = '0;

  dts_in_if  in_if();
  dts_out_if out_if();

  assign in_if.valid   = drv_valid;
  assign in_if.freq_hz = drv_freq;
  assign out_if.ready  = sink_ready;

  dds_tuning_word_serializer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  logic [FREQ_W-1:0] freq_queue[$];
  serial_bit_t       bits_expected[$];
  logic [CTRL_W-1:0] ctrl_byte = '0;
  logic              calm = 1'b0;
  logic              hold_req = 1'b0;
  logic              hold_started = 1'b0;
  int                hold_left = 0;
  int                fail_count = 0;
  int                cycle_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // floor(min(f, fmax) * scale / 1e6) in 64-bit math
  function automatic logic [FTW_W-1:0] tuning_word_of(logic [FREQ_W-1:0] freq);
    longint unsigned f;
    longint unsigned scale;
    longint unsigned hz_per_mhz;
    f = freq;
    if (f > longint'(FREQ_MAX_HZ)) f = FREQ_MAX_HZ;
    scale = FTW_PER_MHZ;
    hz_per_mhz = HZ_PER_MHZ;
    return FTW_W'((f * scale) / hz_per_mhz);
  endfunction

  task automatic queue_serial_bits(logic [FREQ_W-1:0] freq);
    logic [FTW_W-1:0] word;
    serial_bit_t      b;
    word = tuning_word_of(freq);
    for (int k = 0; k < FTW_W; k++) begin
      b.data_bit = word[k];
      b.last_bit = 1'b0;
      bits_expected.push_back(b);
    end
    for (int k = 0; k < CTRL_W; k++) begin
      b.data_bit = ctrl_byte[k];
      b.last_bit = (k == CTRL_W - 1);
      bits_expected.push_back(b);
    end
  endtask

  function automatic logic [FREQ_W-1:0] random_freq();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return FREQ_W'($urandom_range(62500000, 0));
      6: return FREQ_W'($urandom);
      7: return FREQ_W'($urandom_range(1023, 0));
      8: return FREQ_W'($urandom_range(67108863, 62500001));
      default: return FREQ_W'($urandom_range(62500000, 62499000));
    endcase
  endfunction

  // driver: one transaction per handshake, payload held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_if.ready) queue_serial_bits(drv_freq);
      if (!drv_valid || in_if.ready) begin
        if (freq_queue.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          drv_valid <= 1'b1;
          drv_freq <= freq_queue.pop_front();
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the input side backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_req && !hold_started) begin
      hold_left <= HOLD_CYCLES;
      hold_started <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic check_serial_bit(serial_bit_t got);
    serial_bit_t want;
    if (bits_expected.size() == 0) begin
      $error("unexpected transaction: data_bit %0b last_bit %0b", got.data_bit, got.last_bit);
      fail_count++;
    end else begin
      want = bits_expected.pop_front();
      if (got.data_bit !== want.data_bit) begin
        $error("data_bit mismatch: expected %0b actual %0b", want.data_bit, got.data_bit);
        fail_count++;
      end
      if (got.last_bit !== want.last_bit) begin
        $error("last_bit mismatch: expected %0b actual %0b", want.last_bit, got.last_bit);
        fail_count++;
      end
    end
  endtask

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      sink_ready <= 1'b0;
    end else begin
      if (out_if.valid && sink_ready) check_serial_bit({out_if.data_bit, out_if.last_bit});
      sink_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_control(logic [CTRL_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    ctrl_byte = value;
  endtask

  task automatic wait_drained();
    while (freq_queue.size() > 0 || drv_valid || bits_expected.size() > 0) @(posedge clk);
  endtask

  task automatic run_random(logic [CTRL_W-1:0] ctrl, int count, logic no_idle, logic hold);
    write_control(ctrl);
    @(negedge clk);
    calm = no_idle;
    if (hold) hold_req = 1'b1;
    for (int i = 0; i < count; i++) freq_queue.push_back(random_freq());
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, saturation edge, alternating and single-bit patterns
    write_control(8'h00);
    @(negedge clk);
    freq_queue.push_back(26'd0);
    freq_queue.push_back(26'd1);
    freq_queue.push_back(26'd2);
    freq_queue.push_back(26'd999999);
    freq_queue.push_back(26'd1000000);
    freq_queue.push_back(26'd62499999);
    freq_queue.push_back(26'd62500000);
    freq_queue.push_back(26'd62500001);
    freq_queue.push_back(26'h3FFFFFF);
    freq_queue.push_back(26'h2AAAAAA);
    freq_queue.push_back(26'h1555555);
    freq_queue.push_back(26'h2000000);
    freq_queue.push_back(26'h0000029);
    freq_queue.push_back(26'd31250000);
    wait_drained();

    write_control(8'hFF);
    @(negedge clk);
    freq_queue.push_back(26'd0);
    freq_queue.push_back(26'h3FFFFFF);
    freq_queue.push_back(26'd12345678);
    wait_drained();

    run_random(8'hFF, 100, 1'b1, 1'b0);
    run_random(8'h01, 100, 1'b0, 1'b1);
    run_random(8'($urandom), 110, 1'b0, 1'b0);
    run_random(8'hA5, 100, 1'b0, 1'b0);

    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
